@@ src/slcd_pkg.sv @@
package slcd_pkg;

  localparam int ROW_CELLS_DEF   = 16;
  localparam int TOTAL_CELLS_DEF = 32;

  localparam logic [7:0] PRINT_LOW  = 8'h20;
  localparam logic [7:0] PRINT_HIGH = 8'h7E;
  localparam logic [7:0] ROW0_BASE  = 8'h80;
  localparam logic [7:0] ROW1_BASE  = 8'hC0;
  localparam logic [7:0] CMD_CLEAR  = 8'h01;
  localparam logic [7:0] HIGH_MASK  = 8'hF0;

  localparam logic KIND_ECHO = 1'b0;
  localparam logic KIND_LCD  = 1'b1;
  localparam logic RS_CMD    = 1'b0;
  localparam logic RS_DATA   = 1'b1;

  localparam int QUEUE_DEPTH = 2;

  typedef struct packed {
    logic [7:0] char_code;
    logic [7:0] addr;
    logic       clear;
  } job_t;

  typedef enum logic [2:0] {
    STEP_ECHO,
    STEP_ADDR_HI,
    STEP_ADDR_LO,
    STEP_CHAR_HI,
    STEP_CHAR_LO,
    STEP_CLR_HI,
    STEP_CLR_LO
  } step_t;

  function automatic logic [3:0] high_nibble(input logic [7:0] b);
    logic [7:0] m;
    m = b & HIGH_MASK;
    return m[7:4];
  endfunction

endpackage

@@ src/serial_echo_to_char_lcd.sv @@
// Serial echo to 4-bit character LCD writer. One received byte is taken per
// transaction on the rx channel; a byte outside 0x20..0x7E is consumed without
// stalling and produces nothing. A printable byte produces an echo result, the
// set-address command for the cursor cell as two command nibbles, the
// character as two data nibbles, and, when the cursor wraps to cell 0, the
// clear command as two more nibbles; last marks the final result. The output
// stage issues one result per cycle while res_stall is low. The rx side
// classifies bytes combinationally, tracks the cursor and hands work to a
// two-entry queue, so new bytes keep being accepted while results are still
// draining or stalled, until the queue is full and a printable byte stalls.
module serial_echo_to_char_lcd #(
  parameter int ROW_CELLS   = slcd_pkg::ROW_CELLS_DEF,
  parameter int TOTAL_CELLS = slcd_pkg::TOTAL_CELLS_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       rx_valid,
  output logic       rx_stall,
  input  logic [7:0] rx_byte,
  output logic       res_valid,
  input  logic       res_stall,
  output logic       kind,
  output logic [7:0] echo_byte,
  output logic       register_select,
  output logic [3:0] nibble,
  output logic       last
);
  import slcd_pkg::*;

  logic q_full;
  logic q_push;
  logic q_head_valid;
  logic q_pop;
  job_t q_in;
  job_t q_head;

  slcd_front #(
    .ROW_CELLS  (ROW_CELLS),
    .TOTAL_CELLS(TOTAL_CELLS)
  ) u_front (
    .clk     (clk),
    .rst     (rst),
    .rx_valid(rx_valid),
    .rx_stall(rx_stall),
    .rx_byte (rx_byte),
    .q_full  (q_full),
    .q_push  (q_push),
    .q_data  (q_in)
  );

  slcd_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_data (q_in),
    .full      (q_full),
    .head_valid(q_head_valid),
    .head      (q_head),
    .pop       (q_pop)
  );

  slcd_back u_back (
    .clk            (clk),
    .rst            (rst),
    .head_valid     (q_head_valid),
    .head           (q_head),
    .pop            (q_pop),
    .res_valid      (res_valid),
    .res_stall      (res_stall),
    .kind           (kind),
    .echo_byte      (echo_byte),
    .register_select(register_select),
    .nibble         (nibble),
    .last           (last)
  );

endmodule

@@ src/slcd_front.sv @@
module slcd_front #(
  parameter int ROW_CELLS   = slcd_pkg::ROW_CELLS_DEF,
  parameter int TOTAL_CELLS = slcd_pkg::TOTAL_CELLS_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             rx_valid,
  output logic             rx_stall,
  input  logic [7:0]       rx_byte,
  input  logic             q_full,
  output logic             q_push,
  output slcd_pkg::job_t   q_data
);
  import slcd_pkg::*;

  localparam int CW = (TOTAL_CELLS > 1) ? $clog2(TOTAL_CELLS) : 1;

  logic [CW-1:0] cursor;
  logic [CW-1:0] cursor_next;
  logic [CW:0]   cursor_inc;
  logic [7:0]    cell8;
  logic          printable;
  logic          wrap;

  assign printable = (rx_byte >= PRINT_LOW) && (rx_byte <= PRINT_HIGH);
  assign rx_stall  = printable && q_full;
  assign q_push    = rx_valid && printable && !q_full;

  assign cursor_inc = {1'b0, cursor} + (CW+1)'(1);
  assign wrap       = cursor_inc >= (CW+1)'(TOTAL_CELLS);
  assign cursor_next = wrap ? '0 : cursor_inc[CW-1:0];
  assign cell8       = 8'(cursor);

  always_comb begin
    q_data.char_code = rx_byte;
    q_data.clear     = wrap;
    if (cell8 < 8'(ROW_CELLS)) begin
      q_data.addr = ROW0_BASE + cell8;
    end else begin
      q_data.addr = ROW1_BASE + cell8 - 8'(ROW_CELLS);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cursor <= '0;
    end else if (q_push) begin
      cursor <= cursor_next;
    end
  end

endmodule

@@ src/slcd_queue.sv @@
module slcd_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  slcd_pkg::job_t push_data,
  output logic           full,
  output logic           head_valid,
  output slcd_pkg::job_t head,
  input  logic           pop
);
  import slcd_pkg::*;

  localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  job_t             slots [QUEUE_DEPTH];
  logic [PW-1:0]    wr_ptr;
  logic [PW-1:0]    rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_pop;

  assign full       = count == CNT_W'(QUEUE_DEPTH);
  assign head_valid = count != '0;
  assign head       = slots[rd_ptr];
  assign do_pop     = pop && head_valid;

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + PW'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + PW'(1);
      end
      if (push && !do_pop) begin
        count <= count + CNT_W'(1);
      end else if (do_pop && !push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

endmodule

@@ src/slcd_back.sv @@
module slcd_back (
  input  logic           clk,
  input  logic           rst,
  input  logic           head_valid,
  input  slcd_pkg::job_t head,
  output logic           pop,
  output logic           res_valid,
  input  logic           res_stall,
  output logic           kind,
  output logic [7:0]     echo_byte,
  output logic           register_select,
  output logic [3:0]     nibble,
  output logic           last
);
  import slcd_pkg::*;

  step_t      step;
  step_t      step_next;
  logic       load;
  logic       r_kind;
  logic [7:0] r_echo;
  logic       r_rs;
  logic [3:0] r_nib;
  logic       r_last;

  assign load = head_valid && (!res_valid || !res_stall);
  assign pop  = load && r_last;

  always_comb begin
    r_kind    = KIND_LCD;
    r_echo    = '0;
    r_rs      = RS_CMD;
    r_nib     = '0;
    r_last    = 1'b0;
    step_next = STEP_ECHO;
    case (step)
      STEP_ECHO: begin
        r_kind    = KIND_ECHO;
        r_echo    = head.char_code;
        step_next = STEP_ADDR_HI;
      end
      STEP_ADDR_HI: begin
        r_nib     = high_nibble(head.addr);
        step_next = STEP_ADDR_LO;
      end
      STEP_ADDR_LO: begin
        r_nib     = head.addr[3:0];
        step_next = STEP_CHAR_HI;
      end
      STEP_CHAR_HI: begin
        r_rs      = RS_DATA;
        r_nib     = high_nibble(head.char_code);
        step_next = STEP_CHAR_LO;
      end
      STEP_CHAR_LO: begin
        r_rs      = RS_DATA;
        r_nib     = head.char_code[3:0];
        r_last    = !head.clear;
        step_next = head.clear ? STEP_CLR_HI : STEP_ECHO;
      end
      STEP_CLR_HI: begin
        r_nib     = high_nibble(CMD_CLEAR);
        step_next = STEP_CLR_LO;
      end
      STEP_CLR_LO: begin
        r_nib     = CMD_CLEAR[3:0];
        r_last    = 1'b1;
        step_next = STEP_ECHO;
      end
      default: begin
        step_next = STEP_ECHO;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step      <= STEP_ECHO;
      res_valid <= 1'b0;
    end else if (load) begin
      step      <= step_next;
      res_valid <= 1'b1;
    end else if (!res_stall) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      kind            <= r_kind;
      echo_byte       <= r_echo;
      register_select <= r_rs;
      nibble          <= r_nib;
      last            <= r_last;
    end
  end

endmodule
